// ===== rtl/iba_pkg.sv =====
// Shared types and codes for the integer binary ALU.
`timescale 1ns / 1ps
package iba_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_SDIV = 4'd3,
    OP_SREM = 4'd4,
    OP_XOR  = 4'd5,
    OP_SHL  = 4'd6,
    OP_LSHR = 4'd7,
    OP_ASHR = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_DIV_OVF  = 2'd2,
    ST_SHIFT    = 2'd3
  } status_e;

  // execute stage states
  typedef enum logic [1:0] {S_RUN, S_DIV, S_FIX} bstate_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] lhs_operand;
    logic signed [31:0] rhs_operand;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } rsp_t;

endpackage

// ===== rtl/integer_binary_alu.sv =====
// Top level of the integer binary ALU.
`timescale 1ns / 1ps
// Integer ALU: add, sub, mul, signed div/rem, xor and three shifts on WIDTH-bit words.
// Input channel: in_valid_i / in_stall_o carrying an iba_pkg::req_t request.
// Output channel: out_valid_o / out_stall_i carrying an iba_pkg::rsp_t result.
// A front register classifies each request (error status, operand reduction),
// a two-entry queue decouples it from the execute stage.
// Throughput: one request per cycle for non-divide operations while the output is not stalled.
// sdiv/srem run a one-bit-per-cycle restoring divider, and the execute stage
// takes no other request meanwhile.
// Errors (divide by zero, min / -1, shift amount out of range) give result 0
// with status set; unknown opcodes give 0 with status ok.
// Results come out in request order. A stalled result holds; the queue and
// front register keep taking requests until full, then in_stall_o rises.
// Reset empties the front register, queue and output register; no state
// survives between requests.
module integer_binary_alu #(
  parameter int WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  iba_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output iba_pkg::rsp_t out_rsp_o
);
  import iba_pkg::*;

  localparam int QW = 4 + 2 * WIDTH + 2;

  logic             f_valid, f_stall, b_valid, b_stall;
  logic [3:0]       f_op;
  logic [WIDTH-1:0] f_a, f_b;
  logic [1:0]       f_err;
  logic [QW-1:0]    b_data;

  iba_front #(.WIDTH(WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .q_valid_o(f_valid), .q_stall_i(f_stall),
    .q_op_o(f_op), .q_a_o(f_a), .q_b_o(f_b), .q_err_o(f_err)
  );

  iba_queue #(.DW(QW)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i({f_op, f_a, f_b, f_err}),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_data)
  );

  iba_back #(.WIDTH(WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_stall_o(b_stall),
    .q_op_i(b_data[QW-1 -: 4]), .q_a_i(b_data[2*WIDTH+1 -: WIDTH]),
    .q_b_i(b_data[WIDTH+1 -: WIDTH]), .q_err_i(b_data[1:0]),
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

`ifndef SYNTHESIS
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> f_valid)
    else $error("input stalled with empty front register");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != ST_OK) |-> (out_rsp_o.result_value == '0))
    else $error("error result not zero");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_rsp_o))
    else $error("result changed under stall");
`endif

endmodule

// ===== rtl/iba_front.sv =====
// Front end: accepts requests, reduces operands to WIDTH bits and classifies them.
`timescale 1ns / 1ps
module iba_front #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  iba_pkg::req_t    in_req_i,
  output logic             q_valid_o,
  input  logic             q_stall_i,
  output logic [3:0]       q_op_o,
  output logic [WIDTH-1:0] q_a_o,
  output logic [WIDTH-1:0] q_b_o,
  output logic [1:0]       q_err_o
);
  import iba_pkg::*;

  logic             valid_q;
  logic [3:0]       op_q;
  logic [WIDTH-1:0] a_q, b_q;
  logic [1:0]       err_q;
  logic [WIDTH-1:0] a_w, b_w;
  logic [1:0]       err_d;
  logic             take;

  // low WIDTH bits of the sign-extended field
  always_comb begin
    a_w = WIDTH'(64'($signed(in_req_i.lhs_operand)));
    b_w = WIDTH'(64'($signed(in_req_i.rhs_operand)));
  end

  always_comb begin
    err_d = ST_OK;
    case (in_req_i.operation)
      OP_SDIV, OP_SREM: begin
        if (b_w == '0) err_d = ST_DIV_ZERO;
        else if (a_w == {1'b1, {(WIDTH-1){1'b0}}} && b_w == '1) err_d = ST_DIV_OVF;
      end
      OP_SHL, OP_LSHR, OP_ASHR: begin
        if (b_w[WIDTH-1] || b_w >= WIDTH'(WIDTH)) err_d = ST_SHIFT;
      end
      default: err_d = ST_OK;
    endcase
  end

  assign in_stall_o = valid_q && q_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q  <= in_req_i.operation;
      a_q   <= a_w;
      b_q   <= b_w;
      err_q <= err_d;
    end
  end

  assign q_valid_o = valid_q;
  assign q_op_o    = op_q;
  assign q_a_o     = a_q;
  assign q_b_o     = b_q;
  assign q_err_o   = err_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && q_stall_i) |=> (valid_q && $stable(op_q) && $stable(a_q)))
    else $error("front register changed while stalled");
  a_div_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && err_q == ST_DIV_ZERO) |-> (b_q == '0))
    else $error("divide by zero flagged with nonzero divisor");
  a_shift_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && err_q == ST_SHIFT) |-> (op_q == OP_SHL || op_q == OP_LSHR || op_q == OP_ASHR))
    else $error("shift error on non-shift operation");
`endif

endmodule

// ===== rtl/iba_queue.sv =====
// Two-entry queue between the front end and the execute stage.
`timescale 1ns / 1ps
module iba_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_stall_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_stall_i,
  output logic [DW-1:0] rd_data_o
);
  logic [DW-1:0] mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= wr_data_i;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd1) |-> (wptr_q == rptr_q))
    else $error("queue pointers disagree with count");
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |=> (cnt_q != 2'd0))
    else $error("queue drained two at once");
`endif

endmodule

// ===== rtl/iba_back.sv =====
// Execute stage: combinational ops and multiply, plus a radix-2 restoring divider.
`timescale 1ns / 1ps
module iba_back #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_stall_o,
  input  logic [3:0]       q_op_i,
  input  logic [WIDTH-1:0] q_a_i,
  input  logic [WIDTH-1:0] q_b_i,
  input  logic [1:0]       q_err_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output iba_pkg::rsp_t    out_rsp_o
);
  import iba_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  bstate_e          state_q, state_d;
  logic             ovalid_q;
  logic [WIDTH-1:0] res_q;
  logic [1:0]       st_q;
  // divider state
  logic [WIDTH-1:0] quo_q, rem_q, dvs_q, dnd_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q, rneg_q, isrem_q;
  logic             out_free, fast_ok, start_div;
  logic [WIDTH-1:0] fast_res;
  logic [WIDTH-1:0] ma, mb;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH-1:0] div_res;
  logic [WIDTH-1:0] sh_fill;
  logic [$clog2(WIDTH)-1:0] sh;

  assign out_free = !ovalid_q || !out_stall_i;
  assign sh = q_b_i[$clog2(WIDTH)-1:0];
  assign sh_fill = ~({WIDTH{1'b1}} >> sh);

  always_comb begin
    fast_res = '0;
    if (q_err_i == ST_OK) begin
      case (q_op_i)
        OP_ADD:  fast_res = q_a_i + q_b_i;
        OP_SUB:  fast_res = q_a_i - q_b_i;
        OP_MUL:  fast_res = WIDTH'(q_a_i * q_b_i);
        OP_XOR:  fast_res = q_a_i ^ q_b_i;
        OP_SHL:  fast_res = q_a_i << sh;
        OP_LSHR: fast_res = q_a_i >> sh;
        OP_ASHR: fast_res = (q_a_i >> sh) | (q_a_i[WIDTH-1] ? sh_fill : '0);
        default: fast_res = '0;
      endcase
    end
  end

  assign start_div = (q_op_i == OP_SDIV || q_op_i == OP_SREM) && q_err_i == ST_OK;
  assign ma = q_a_i[WIDTH-1] ? -q_a_i : q_a_i;
  assign mb = q_b_i[WIDTH-1] ? -q_b_i : q_b_i;

  assign rem_sh = {rem_q[WIDTH-2:0], dnd_q[WIDTH-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};
  assign div_res = isrem_q ? (rneg_q ? -rem_q : rem_q) : (neg_q ? -quo_q : quo_q);

  always_comb begin
    state_d   = state_q;
    q_stall_o = 1'b1;
    fast_ok   = 1'b0;
    case (state_q)
      S_RUN: begin
        if (q_valid_i && start_div) begin
          state_d = S_DIV;
        end else begin
          q_stall_o = !out_free;
          fast_ok   = q_valid_i && out_free;
        end
      end
      S_DIV: if (cnt_q == CW'(1)) state_d = S_FIX;
      S_FIX: if (out_free) begin
        state_d   = S_RUN;
        q_stall_o = 1'b0;
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RUN;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_free) ovalid_q <= fast_ok || (state_q == S_FIX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fast_ok) begin
      res_q <= fast_res;
      st_q  <= q_err_i;
    end else if (state_q == S_FIX && out_free) begin
      res_q <= div_res;
      st_q  <= ST_OK;
    end
    if (state_q == S_RUN) begin
      dnd_q   <= ma;
      dvs_q   <= mb;
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= CW'(WIDTH);
      neg_q   <= q_a_i[WIDTH-1] ^ q_b_i[WIDTH-1];
      rneg_q  <= q_a_i[WIDTH-1];
      isrem_q <= (q_op_i == OP_SREM);
    end else if (state_q == S_DIV) begin
      dnd_q <= dnd_q << 1;
      rem_q <= trial[WIDTH] ? rem_sh : trial[WIDTH-1:0];
      quo_q <= {quo_q[WIDTH-2:0], ~trial[WIDTH]};
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_rsp_o.result_value = 32'($signed(res_q));
  assign out_rsp_o.status = st_q;

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q != '0))
    else $error("divider ran past its last step");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> (ovalid_q && $stable(res_q)))
    else $error("result changed while stalled");
  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> q_stall_o)
    else $error("queue popped during divide");
`endif

endmodule

// ===== test/testbench.sv =====
// Testbench for the integer binary ALU: directed table plus random requests, checked by a predictor.
`timescale 1ns / 1ps
module testbench;
  import iba_pkg::*;

  localparam int W = 32;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  req_t  in_req_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  rsp_t  out_rsp_o;

  integer_binary_alu #(.WIDTH(W)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Directed row: request plus an optional typed-in answer.
  typedef struct {
    req_t  req;
    bit    typed;
    rsp_t  rsp;
  } vec_t;

  rsp_t  pending_rsps[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    hold_off = 1'b0;
  vec_t  vecs[$];

  localparam logic [31:0] MIN_V = 32'h8000_0000;
  localparam logic [31:0] MAX_V = 32'h7fff_ffff;
  localparam logic [31:0] NEG1  = 32'hffff_ffff;

  // Bit-accurate ALU result for one request.
  function automatic rsp_t alu_result(req_t r);
    rsp_t        o;
    logic [31:0] a, b, ma, mb, q, m;
    logic [63:0] p;
    o = '0;
    o.status = ST_OK;
    a = r.lhs_operand;
    b = r.rhs_operand;
    case (r.operation)
      OP_ADD: o.result_value = a + b;
      OP_SUB: o.result_value = a - b;
      OP_MUL: begin
        p = a * b;
        o.result_value = p[31:0];
      end
      OP_SDIV, OP_SREM: begin
        if (b == 0) begin
          o.status = ST_DIV_ZERO;
        end else if (a == MIN_V && b == NEG1) begin
          o.status = ST_DIV_OVF;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          m = ma % mb;
          if (r.operation == OP_SDIV) o.result_value = (a[31] ^ b[31]) ? -q : q;
          else o.result_value = a[31] ? -m : m;
        end
      end
      OP_XOR: o.result_value = a ^ b;
      OP_SHL, OP_LSHR, OP_ASHR: begin
        if (b[31] || b >= W) begin
          o.status = ST_SHIFT;
        end else if (r.operation == OP_SHL) begin
          o.result_value = a << b[4:0];
        end else if (r.operation == OP_LSHR) begin
          o.result_value = a >> b[4:0];
        end else begin
          o.result_value = $signed(a) >>> b[4:0];
        end
      end
      default: o.result_value = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic logic [31:0] rnd_operand();
    case ($urandom_range(0, 7))
      0: return MIN_V;
      1: return MAX_V;
      2: return NEG1;
      3: return 32'($urandom_range(0, 3));
      4: return -32'($urandom_range(1, 300));
      5: return 32'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rnd_request();
    req_t r;
    r.operation = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
    r.lhs_operand = rnd_operand();
    r.rhs_operand = rnd_operand();
    // shifts: mostly in-range amounts, sometimes the edges
    if (r.operation inside {OP_SHL, OP_LSHR, OP_ASHR} && $urandom_range(0, 3) != 0)
      r.rhs_operand = 32'($urandom_range(0, 32));
    // divides: mostly nonzero divisors
    if (r.operation inside {OP_SDIV, OP_SREM} && r.rhs_operand == 0
        && $urandom_range(0, 3) != 0)
      r.rhs_operand = 32'($urandom_range(1, 9));
    return r;
  endfunction

  // Drive one request; predict it at acceptance. Valid stays up between
  // back-to-back requests and drops only on idle cycles.
  task automatic send_request(req_t r, bit typed, rsp_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    pending_rsps.push_back(typed ? want : alu_result(r));
    if (typed && want != alu_result(r))
      $display("note: table row disagrees with predictor, op %0d", r.operation);
    @(negedge clk_i);
  endtask

  function automatic void add_row(op_e op, logic [31:0] a, logic [31:0] b,
                                  bit typed = 0, logic [31:0] v = 0,
                                  status_e st = ST_OK);
    vec_t x;
    x.req.operation = op;
    x.req.lhs_operand = a;
    x.req.rhs_operand = b;
    x.typed = typed;
    x.rsp.result_value = v;
    x.rsp.status = st;
    vecs.push_back(x);
  endfunction

  // Receiver: random stall, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Checker at the rising edge.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsps.size() == 0) begin
        report_mismatch("unexpected result", out_rsp_o.result_value, 32'd0);
      end else begin
        want = pending_rsps.pop_front();
        if (out_rsp_o.result_value !== want.result_value)
          report_mismatch("result_value", out_rsp_o.result_value, want.result_value);
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
      end
    end
  end

  initial begin
    rsp_t dummy;
    int   cnt;
    dummy = '0;
    // directed: extremes, every op, each error case
    add_row(OP_ADD, MAX_V, 32'd1, 1, MIN_V);
    add_row(OP_ADD, MIN_V, NEG1, 1, MAX_V);
    add_row(OP_SUB, MIN_V, 32'd1, 1, MAX_V);
    add_row(OP_SUB, 32'd0, MIN_V, 1, MIN_V);
    add_row(OP_MUL, MAX_V, MAX_V, 1, 32'd1);
    add_row(OP_MUL, 32'h1234_5678, 32'h9abc_def0);
    add_row(OP_SDIV, 32'd7, 32'd0, 1, 32'd0, ST_DIV_ZERO);
    add_row(OP_SREM, MIN_V, 32'd0, 1, 32'd0, ST_DIV_ZERO);
    add_row(OP_SDIV, MIN_V, NEG1, 1, 32'd0, ST_DIV_OVF);
    add_row(OP_SREM, MIN_V, NEG1, 1, 32'd0, ST_DIV_OVF);
    add_row(OP_SDIV, -32'd7, 32'd2, 1, -32'd3);
    add_row(OP_SREM, -32'd7, 32'd2, 1, NEG1);
    add_row(OP_SDIV, MIN_V, 32'd1, 1, MIN_V);
    add_row(OP_SREM, MAX_V, MIN_V);
    add_row(OP_XOR, MIN_V, NEG1, 1, MAX_V);
    add_row(OP_SHL, NEG1, 32'd31, 1, MIN_V);
    add_row(OP_SHL, 32'd1, 32'd32, 1, 32'd0, ST_SHIFT);
    add_row(OP_LSHR, MIN_V, 32'd31, 1, 32'd1);
    add_row(OP_LSHR, MIN_V, NEG1, 1, 32'd0, ST_SHIFT);
    add_row(OP_ASHR, MIN_V, 32'd31, 1, NEG1);
    add_row(OP_ASHR, MAX_V, MIN_V, 1, 32'd0, ST_SHIFT);
    add_row(OP_ASHR, MIN_V, 32'd0, 1, MIN_V);
    add_row(op_e'(4'd15), NEG1, NEG1, 1, 32'd0);
    add_row(op_e'(4'd9), MAX_V, 32'd3, 1, 32'd0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (vecs[i]) send_request(vecs[i].req, vecs[i].typed, vecs[i].rsp);

    // three idle phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 30 : 0;
      for (int n = 0; n < 440; n++) send_request(rnd_request(), 0, dummy);
    end

    // back-pressure: receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        cnt = 0;
        while (cnt < 200) begin
          @(posedge clk_i);
          cnt++;
        end
        hold_off = 1'b0;
      end
      for (int n = 0; n < 30; n++) send_request(rnd_request(), 0, dummy);
    join

    in_valid_i <= 1'b0;
    wait (pending_rsps.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 400000);
    $display("status: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/iba_pkg.sv
rtl/iba_front.sv
rtl/iba_queue.sv
rtl/iba_back.sv
rtl/integer_binary_alu.sv
test/testbench.sv
